// ===== hdl/csvs_pkg.sv =====
// shared types, constants and codes for the csv line field splitter
package csvs_pkg;

  localparam int PEND_DEPTH = 16;
  localparam int PEND_CNT_W = $clog2(PEND_DEPTH + 1);
  localparam int PEND_IDX_W = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  localparam int LEN_W = 11;
  localparam int FIELD_W = 11;

  localparam logic [LEN_W-1:0] LINE_LIMIT_MAX = LEN_W'(1024);
  localparam logic [LEN_W-1:0] LEN_MAX = '1;
  localparam logic [FIELD_W-1:0] FIELD_MAX = FIELD_W'(1024);

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_COMMA = 2'd1,
    KIND_ROW   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_LONG = 2'd1,
    ST_OVF  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_CHAR  = 2'd0,
    CMD_SPACE = 2'd1,
    CMD_EOL   = 2'd2
  } cmd_op_t;

  typedef enum logic [1:0] {
    PS_UNQ = 2'd0,
    PS_QUO = 2'd1,
    PS_QQ  = 2'd2
  } parse_t;

  typedef enum logic [1:0] {
    SQ_IDLE   = 2'd0,
    SQ_REPLAY = 2'd1,
    SQ_FLUSH  = 2'd2
  } seq_t;

  typedef struct packed {
    logic       func;
    logic [7:0] char_byte;
  } in_item_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         field_byte;
    logic [FIELD_W-1:0] field_index;
    status_t            row_status;
    logic               last;
  } result_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] char_byte;
  } cmd_t;

endpackage

// ===== hdl/csvs_front.sv =====
// front end: accepts items, drops leading whitespace, classifies into commands
module csvs_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  csvs_pkg::in_item_t  item,
  output logic                q_wr,
  output csvs_pkg::cmd_t      q_cmd,
  input  logic                q_full
);

  logic seen_non_space;
  logic seen_non_space_next;
  logic is_space;
  logic accept;
  logic keep;

  assign full = q_full;
  assign accept = push && !q_full;

  always_comb begin
    is_space = (item.char_byte == csvs_pkg::CH_SPACE) ||
               ((item.char_byte >= csvs_pkg::CH_TAB) && (item.char_byte <= csvs_pkg::CH_CR));
    q_cmd.char_byte = item.char_byte;
    keep = 1'b1;
    seen_non_space_next = seen_non_space;
    if (item.func) begin
      q_cmd.op = csvs_pkg::CMD_EOL;
      seen_non_space_next = 1'b0;
    end else if (is_space) begin
      q_cmd.op = csvs_pkg::CMD_SPACE;
      keep = seen_non_space;
    end else begin
      q_cmd.op = csvs_pkg::CMD_CHAR;
      seen_non_space_next = 1'b1;
    end
  end

  assign q_wr = accept && keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_non_space <= 1'b0;
    end else if (accept) begin
      seen_non_space <= seen_non_space_next;
    end
  end

endmodule

// ===== hdl/csvs_cmd_q.sv =====
// short command queue between front end and back end
module csvs_cmd_q (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  csvs_pkg::cmd_t  wr_cmd,
  output logic            full,
  input  logic            rd_en,
  output csvs_pkg::cmd_t  rd_cmd,
  output logic            empty
);

  csvs_pkg::cmd_t                    entries [csvs_pkg::CMDQ_DEPTH];
  logic [csvs_pkg::CMDQ_PTR_W-1:0]   wr_ptr;
  logic [csvs_pkg::CMDQ_PTR_W-1:0]   rd_ptr;
  logic [csvs_pkg::CMDQ_CNT_W-1:0]   count;
  logic                              do_wr;
  logic                              do_rd;

  assign full = (count == csvs_pkg::CMDQ_CNT_W'(csvs_pkg::CMDQ_DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == csvs_pkg::CMDQ_PTR_W'(csvs_pkg::CMDQ_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == csvs_pkg::CMDQ_PTR_W'(csvs_pkg::CMDQ_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/csvs_back.sv =====
// back end: whitespace hold store, replay sequencer, quote machine, result register
module csvs_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [csvs_pkg::LEN_W-1:0]    max_len,
  input  csvs_pkg::cmd_t                q_cmd,
  input  logic                          q_empty,
  output logic                          q_rd,
  output logic                          empty,
  input  logic                          pop,
  output csvs_pkg::result_t             result
);

  csvs_pkg::seq_t                       sq;
  csvs_pkg::seq_t                       sq_next;
  csvs_pkg::parse_t                     parse_st;
  logic [csvs_pkg::FIELD_W-1:0]         current_field;
  logic [csvs_pkg::LEN_W-1:0]           committed_length;
  logic                                 space_overflow;
  logic [7:0]                           pend_mem [csvs_pkg::PEND_DEPTH];
  logic [csvs_pkg::PEND_CNT_W-1:0]      pend_cnt;
  logic [csvs_pkg::PEND_IDX_W-1:0]      pend_idx;
  logic                                 hold_valid;
  csvs_pkg::result_t                    hold;
  logic                                 out_valid;
  csvs_pkg::result_t                    out_item;

  logic                                 out_free;
  logic                                 cmd_avail;
  logic                                 replay_last;
  logic [7:0]                           step_byte;
  csvs_pkg::parse_t                     f_state;
  logic [csvs_pkg::FIELD_W-1:0]         f_field;
  logic                                 f_valid;
  csvs_pkg::result_t                    f_res;
  logic [csvs_pkg::LEN_W-1:0]           len_inc;
  csvs_pkg::status_t                    row_status;

  logic                                 do_step;
  logic                                 step_final;
  logic                                 do_eol;
  logic                                 do_space;
  logic                                 do_flush;
  logic                                 emit;
  csvs_pkg::result_t                    emit_res;

  assign out_free = !out_valid || pop;
  assign cmd_avail = !q_empty;
  assign replay_last = ((csvs_pkg::PEND_CNT_W'(pend_idx) + csvs_pkg::PEND_CNT_W'(1)) == pend_cnt);
  assign step_byte = (sq == csvs_pkg::SQ_REPLAY) ? pend_mem[pend_idx] : q_cmd.char_byte;
  assign len_inc = (committed_length == csvs_pkg::LEN_MAX) ?
                   committed_length : committed_length + 1'b1;
  assign empty = !out_valid;
  assign result = out_item;

  // quote machine for one committed byte
  always_comb begin
    f_state = csvs_pkg::PS_UNQ;
    f_field = current_field;
    f_valid = 1'b0;
    f_res.kind = csvs_pkg::KIND_DATA;
    f_res.field_byte = step_byte;
    f_res.field_index = current_field;
    f_res.row_status = csvs_pkg::ST_OK;
    f_res.last = 1'b0;
    case (parse_st)
      csvs_pkg::PS_QUO: begin
        if (step_byte == csvs_pkg::CH_QUOTE) begin
          f_state = csvs_pkg::PS_QQ;
        end else begin
          f_state = csvs_pkg::PS_QUO;
          f_valid = 1'b1;
        end
      end
      csvs_pkg::PS_QQ: begin
        if (step_byte == csvs_pkg::CH_COMMA) begin
          f_valid = 1'b1;
          f_res.kind = csvs_pkg::KIND_COMMA;
          f_res.field_byte = 8'h00;
          if (current_field < csvs_pkg::FIELD_MAX) begin
            f_field = current_field + 1'b1;
          end
        end else if (step_byte == csvs_pkg::CH_QUOTE) begin
          f_valid = 1'b1;
          f_state = csvs_pkg::PS_QUO;
        end
      end
      default: begin
        if (step_byte == csvs_pkg::CH_COMMA) begin
          f_valid = 1'b1;
          f_res.kind = csvs_pkg::KIND_COMMA;
          f_res.field_byte = 8'h00;
          if (current_field < csvs_pkg::FIELD_MAX) begin
            f_field = current_field + 1'b1;
          end
        end else if (step_byte == csvs_pkg::CH_QUOTE) begin
          f_state = csvs_pkg::PS_QUO;
        end else begin
          f_valid = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    if (space_overflow) begin
      row_status = csvs_pkg::ST_OVF;
    end else if (committed_length > max_len) begin
      row_status = csvs_pkg::ST_LONG;
    end else begin
      row_status = csvs_pkg::ST_OK;
    end
  end

  // next state
  always_comb begin
    sq_next = sq;
    case (sq)
      csvs_pkg::SQ_IDLE: begin
        if (cmd_avail && out_free && (q_cmd.op == csvs_pkg::CMD_CHAR)) begin
          if (pend_cnt != '0) begin
            sq_next = csvs_pkg::SQ_REPLAY;
          end else if (f_valid && hold_valid) begin
            sq_next = csvs_pkg::SQ_FLUSH;
          end
        end
      end
      csvs_pkg::SQ_REPLAY: begin
        if (out_free && replay_last) begin
          sq_next = csvs_pkg::SQ_IDLE;
        end
      end
      csvs_pkg::SQ_FLUSH: begin
        if (out_free) begin
          sq_next = csvs_pkg::SQ_IDLE;
        end
      end
      default: sq_next = csvs_pkg::SQ_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    q_rd = 1'b0;
    do_step = 1'b0;
    step_final = 1'b0;
    do_eol = 1'b0;
    do_space = 1'b0;
    do_flush = 1'b0;
    emit = 1'b0;
    emit_res = hold;
    case (sq)
      csvs_pkg::SQ_IDLE: begin
        if (cmd_avail && out_free) begin
          case (q_cmd.op)
            csvs_pkg::CMD_EOL: begin
              q_rd = 1'b1;
              do_eol = 1'b1;
              emit = 1'b1;
              emit_res.kind = csvs_pkg::KIND_ROW;
              emit_res.field_byte = 8'h00;
              emit_res.field_index = current_field;
              emit_res.row_status = row_status;
              emit_res.last = 1'b1;
            end
            csvs_pkg::CMD_SPACE: begin
              q_rd = 1'b1;
              do_space = 1'b1;
            end
            csvs_pkg::CMD_CHAR: begin
              if (pend_cnt == '0) begin
                q_rd = 1'b1;
                do_step = 1'b1;
                step_final = 1'b1;
                emit = f_valid || hold_valid;
                if (hold_valid) begin
                  emit_res = hold;
                  emit_res.last = !f_valid;
                end else begin
                  emit_res = f_res;
                  emit_res.last = 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      csvs_pkg::SQ_REPLAY: begin
        if (out_free) begin
          do_step = 1'b1;
          emit = f_valid && hold_valid;
          emit_res = hold;
          emit_res.last = 1'b0;
        end
      end
      csvs_pkg::SQ_FLUSH: begin
        if (out_free) begin
          do_flush = 1'b1;
          emit = 1'b1;
          emit_res = hold;
          emit_res.last = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_space && (pend_cnt < csvs_pkg::PEND_CNT_W'(csvs_pkg::PEND_DEPTH))) begin
      pend_mem[pend_cnt[csvs_pkg::PEND_IDX_W-1:0]] <= q_cmd.char_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (do_step && f_valid && (!step_final || hold_valid)) begin
      hold <= f_res;
    end
    if (emit) begin
      out_item <= emit_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq <= csvs_pkg::SQ_IDLE;
      parse_st <= csvs_pkg::PS_UNQ;
      current_field <= '0;
      committed_length <= '0;
      space_overflow <= 1'b0;
      pend_cnt <= '0;
      pend_idx <= '0;
      hold_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      sq <= sq_next;
      if (do_step) begin
        parse_st <= f_state;
        current_field <= f_field;
        committed_length <= len_inc;
      end
      if (do_step && !step_final) begin
        if (replay_last) begin
          pend_idx <= '0;
          pend_cnt <= '0;
        end else begin
          pend_idx <= pend_idx + 1'b1;
        end
      end
      if (do_space) begin
        if (pend_cnt < csvs_pkg::PEND_CNT_W'(csvs_pkg::PEND_DEPTH)) begin
          pend_cnt <= pend_cnt + 1'b1;
        end else begin
          space_overflow <= 1'b1;
        end
      end
      if (do_eol) begin
        parse_st <= csvs_pkg::PS_UNQ;
        current_field <= '0;
        committed_length <= '0;
        space_overflow <= 1'b0;
        pend_cnt <= '0;
      end
      if (do_step && f_valid && (!step_final || hold_valid)) begin
        hold_valid <= 1'b1;
      end else if ((do_step && step_final) || do_flush) begin
        hold_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    pend_cnt <= csvs_pkg::PEND_CNT_W'(csvs_pkg::PEND_DEPTH))
    else $error("held whitespace count beyond store depth");

  a_replay_nonempty: assert property (@(posedge clk) disable iff (rst)
    (sq == csvs_pkg::SQ_REPLAY) |-> (pend_cnt != '0))
    else $error("replay with no held whitespace");

  a_flush_hold: assert property (@(posedge clk) disable iff (rst)
    (sq == csvs_pkg::SQ_FLUSH) |-> hold_valid)
    else $error("flush without a held result");

  a_eol_no_hold: assert property (@(posedge clk) disable iff (rst)
    do_eol |-> !hold_valid)
    else $error("row end while a result is still held");

  a_field_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.field_index <= csvs_pkg::FIELD_MAX))
    else $error("field index past saturation");
`endif

endmodule

// ===== hdl/csv_line_field_splitter_core.sv =====
// top level of the csv line field splitter
//
// Input queue side: item carries func (0 character, 1 end of line) and the
// character byte; it is taken at a clock edge with push high and full low.
// Result queue side: while empty is low the oldest result is on result;
// it is taken at a clock edge with pop high. Every item that causes
// results marks its final one with last.
// Configuration: cfg_data is the line length limit, written when cfg_valid
// and cfg_ready are both high; cfg_ready is always high. Values above 1024
// are taken as 1024.
// Path: an item is written into the command queue, then the back end registers its result.
// Throughput: a character that follows a held whitespace run first replays the
// run, then a flush follows when both the run and the character end in a result.
// While the result register is free the back end steps one byte per cycle
// through the quote machine and a single result register; a four-entry command
// queue lets the front keep taking items.
// Reset clears row state, the queues and the limit (back to 1024).
// When pop stays low the result register holds, the back end stops and
// full rises once the command queue fills.
module csv_line_field_splitter_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  csvs_pkg::in_item_t            item,
  output logic                          empty,
  input  logic                          pop,
  output csvs_pkg::result_t             result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [csvs_pkg::LEN_W-1:0]    cfg_data
);

  logic [csvs_pkg::LEN_W-1:0] max_len;
  logic                       q_wr;
  csvs_pkg::cmd_t             q_wr_cmd;
  logic                       q_full;
  logic                       q_rd;
  csvs_pkg::cmd_t             q_rd_cmd;
  logic                       q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= csvs_pkg::LINE_LIMIT_MAX;
    end else if (cfg_valid && cfg_ready) begin
      max_len <= (cfg_data > csvs_pkg::LINE_LIMIT_MAX) ? csvs_pkg::LINE_LIMIT_MAX : cfg_data;
    end
  end

  csvs_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .q_wr   (q_wr),
    .q_cmd  (q_wr_cmd),
    .q_full (q_full)
  );

  csvs_cmd_q u_cmd_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (q_wr),
    .wr_cmd (q_wr_cmd),
    .full   (q_full),
    .rd_en  (q_rd),
    .rd_cmd (q_rd_cmd),
    .empty  (q_empty)
  );

  csvs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .max_len (max_len),
    .q_cmd   (q_rd_cmd),
    .q_empty (q_empty),
    .q_rd    (q_rd),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule
